/* sv/minv_pkg.sv */
package minv_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK             = 2'd0,
      STATUS_BAD_MODULUS    = 2'd1,
      STATUS_NOT_INVERTIBLE = 2'd2
   } status_type;

   // Register map: index is paddr[2], one 32-bit register per word
   typedef enum logic {
      REG_MODULUS = 1'b0
   } reg_index_type;

   localparam int unsigned MODULUS_RESET = 27;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   // Microprogram step addresses
   typedef enum logic [3:0] {
      ST_WAIT   = 4'd0,
      ST_CHECK  = 4'd1,
      ST_INIT   = 4'd2,
      ST_ALIGN  = 4'd3,
      ST_SUB    = 4'd4,
      ST_SWAP   = 4'd5,
      ST_FINISH = 4'd6,
      ST_FIX    = 4'd7,
      ST_FAIL   = 4'd8
   } step_type;

   // Datapath operations
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_ALIGN_INIT,
      DP_ALIGN,
      DP_SUB,
      DP_SWAP,
      DP_EMIT_OK,
      DP_EMIT_FAIL
   } dp_op_type;

   // Branch conditions
   typedef enum logic [2:0] {
      C_ALWAYS,
      C_REQ_FIRE,
      C_BAD_INPUT,
      C_R1_ZERO,
      C_CAN_SHIFT,
      C_K_ZERO,
      C_GCD_ONE,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      step_type  jmp_true;
      step_type  jmp_false;
      logic      accept;
   } uop_type;

   typedef struct packed {
      logic req_fire;
      logic bad_input;
      logic r1_zero;
      logic can_shift;
      logic k_zero;
      logic gcd_one;
      logic out_free;
   } flags_type;

   // Control store
   function automatic uop_type ucode_rom(step_type step);
      uop_type u;
      case (step)
         ST_WAIT: begin
            u = '{op: DP_LOAD, cond: C_REQ_FIRE, jmp_true: ST_CHECK,
                  jmp_false: ST_WAIT, accept: 1'b1};
         end
         ST_CHECK: begin
            u = '{op: DP_NOP, cond: C_BAD_INPUT, jmp_true: ST_FAIL,
                  jmp_false: ST_INIT, accept: 1'b0};
         end
         ST_INIT: begin
            u = '{op: DP_ALIGN_INIT, cond: C_R1_ZERO, jmp_true: ST_FINISH,
                  jmp_false: ST_ALIGN, accept: 1'b0};
         end
         ST_ALIGN: begin
            u = '{op: DP_ALIGN, cond: C_CAN_SHIFT, jmp_true: ST_ALIGN,
                  jmp_false: ST_SUB, accept: 1'b0};
         end
         ST_SUB: begin
            u = '{op: DP_SUB, cond: C_K_ZERO, jmp_true: ST_SWAP,
                  jmp_false: ST_SUB, accept: 1'b0};
         end
         ST_SWAP: begin
            u = '{op: DP_SWAP, cond: C_ALWAYS, jmp_true: ST_INIT,
                  jmp_false: ST_INIT, accept: 1'b0};
         end
         ST_FINISH: begin
            u = '{op: DP_NOP, cond: C_GCD_ONE, jmp_true: ST_FIX,
                  jmp_false: ST_FAIL, accept: 1'b0};
         end
         ST_FIX: begin
            u = '{op: DP_EMIT_OK, cond: C_OUT_FREE, jmp_true: ST_WAIT,
                  jmp_false: ST_FIX, accept: 1'b0};
         end
         ST_FAIL: begin
            u = '{op: DP_EMIT_FAIL, cond: C_OUT_FREE, jmp_true: ST_WAIT,
                  jmp_false: ST_FAIL, accept: 1'b0};
         end
         default: begin
            u = '{op: DP_NOP, cond: C_ALWAYS, jmp_true: ST_WAIT,
                  jmp_false: ST_WAIT, accept: 1'b0};
         end
      endcase
      return u;
   endfunction

endpackage

/* sv/modular_inverse_unit_top.sv */
// Modular inverse unit: returns b with value*b mod modulus == 1.
// Input channel (req_*): one beat carries a value; accepted when req_valid
// is high and req_stall low. Output channel (rsp_*): one beat per input beat,
// carrying the inverse and a status (ok, modulus below two, not invertible).
// The modulus sits in a CSR at byte address 0, reset value 27; write it only
// while the block is idle.
// Operation: the extended Euclid runs on a shift-and-subtract datapath under a
// small microprogram. Each Euclid step doubles the divisor up to the remainder,
// subtracts one quotient bit at a time while halving the divisor back down, and
// then swaps remainder and divisor. Rejected inputs go from the input check
// straight to the failure result.
// Throughput: one item at a time; req_stall drops again the cycle after the
// result beat is loaded into the output register.
// Stall: the result register holds its beat while rsp_stall is high; a new
// item may already be accepted and worked on, and it waits at its final step
// until the register frees.
// Reset: synchronous, clears the sequencer and output valid, restores the
// modulus to 27.
module modular_inverse_unit_top #(
   parameter int unsigned WORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [WORD_BITS-1:0]                   req_value,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [WORD_BITS-1:0]                   rsp_inverse,
   output logic [1:0]                             rsp_status,
   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [minv_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [minv_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [minv_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   minv_pkg::uop_type   uop;
   minv_pkg::flags_type flags;

   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic                 csr_wr;
   logic                 reg_hit;

   // ---- CSR block ----
   // word address is paddr[2]; anything past the modulus is ignored
   assign reg_hit    = csr_paddr[2] == minv_pkg::REG_MODULUS;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign modulus_in = (csr_wr && reg_hit) ? csr_pwdata[WORD_BITS-1:0] : modulus_ff;
   assign csr_prdata = reg_hit ? minv_pkg::CSR_DATA_BITS'(modulus_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WORD_BITS'(minv_pkg::MODULUS_RESET);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // ---- microprogram sequencer ----
   minv_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uop   (uop)
   );

   // only the wait step takes a beat
   assign req_stall = !uop.accept;

   // ---- Euclid datapath and result register ----
   minv_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .op          (uop.op),
      .req_valid   (req_valid),
      .req_value   (req_value),
      .modulus     (modulus_ff),
      .rsp_stall   (rsp_stall),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_inverse (rsp_inverse),
      .rsp_status  (rsp_status)
   );

   // once a beat is taken the block is busy the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("modular_inverse_unit_top: second beat taken while busy");

endmodule

/* sv/minv_seq.sv */
module minv_seq (
   input  logic                clock,
   input  logic                reset,
   input  minv_pkg::flags_type flags,
   output minv_pkg::uop_type   uop
);

   minv_pkg::step_type upc_ff;
   minv_pkg::step_type upc_in;
   logic               cond_true;

   // control word of the current step
   always_comb begin
      uop = minv_pkg::ucode_rom(upc_ff);
   end

   // branch select
   always_comb begin
      case (uop.cond)
         minv_pkg::C_ALWAYS:    cond_true = 1'b1;
         minv_pkg::C_REQ_FIRE:  cond_true = flags.req_fire;
         minv_pkg::C_BAD_INPUT: cond_true = flags.bad_input;
         minv_pkg::C_R1_ZERO:   cond_true = flags.r1_zero;
         minv_pkg::C_CAN_SHIFT: cond_true = flags.can_shift;
         minv_pkg::C_K_ZERO:    cond_true = flags.k_zero;
         minv_pkg::C_GCD_ONE:   cond_true = flags.gcd_one;
         minv_pkg::C_OUT_FREE:  cond_true = flags.out_free;
         default:               cond_true = 1'b1;
      endcase
      upc_in = cond_true ? uop.jmp_true : uop.jmp_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= minv_pkg::ST_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* sv/minv_dpath.sv */
module minv_dpath #(
   parameter int unsigned WORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  minv_pkg::dp_op_type   op,
   input  logic                  req_valid,
   input  logic [WORD_BITS-1:0]  req_value,
   input  logic [WORD_BITS-1:0]  modulus,
   input  logic                  rsp_stall,
   output minv_pkg::flags_type   flags,
   output logic                  rsp_valid,
   output logic [WORD_BITS-1:0]  rsp_inverse,
   output logic [1:0]            rsp_status
);

   // coefficients stay within +/-2n: two guard bits
   localparam int unsigned CW = WORD_BITS + 2;
   localparam int unsigned KW = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0]        r0_ff, r0_in;
   logic [WORD_BITS-1:0]        r1_ff, r1_in;
   logic [WORD_BITS-1:0]        d_ff, d_in;
   logic signed [CW-1:0]        t0_ff, t0_in;
   logic signed [CW-1:0]        t1_ff, t1_in;
   logic signed [CW-1:0]        e_ff, e_in;
   logic [KW-1:0]               k_ff, k_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]        rsp_inverse_ff, rsp_inverse_in;
   minv_pkg::status_type        rsp_status_ff, rsp_status_in;

   logic [WORD_BITS:0]          d_dbl;
   logic                        can_shift;
   logic                        out_free;
   logic                        emit;
   logic signed [CW-1:0]        t0_fix;

   assign d_dbl     = {d_ff, 1'b0};
   assign can_shift = d_dbl <= {1'b0, r0_ff};
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = out_free && (op == minv_pkg::DP_EMIT_OK || op == minv_pkg::DP_EMIT_FAIL);
   assign t0_fix    = t0_ff[CW-1] ? t0_ff + $signed({2'b00, modulus}) : t0_ff;

   always_comb begin
      flags.req_fire  = req_valid && op == minv_pkg::DP_LOAD;
      flags.bad_input = (r0_ff < WORD_BITS'(2)) || (r1_ff == '0) || (r1_ff >= r0_ff);
      flags.r1_zero   = r1_ff == '0;
      flags.can_shift = can_shift;
      flags.k_zero    = k_ff == '0;
      flags.gcd_one   = r0_ff == WORD_BITS'(1);
      flags.out_free  = out_free;
   end

   always_comb begin
      r0_in = r0_ff;
      r1_in = r1_ff;
      d_in  = d_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      e_in  = e_ff;
      k_in  = k_ff;
      case (op)
         minv_pkg::DP_LOAD: begin
            if (req_valid) begin
               r0_in = modulus;
               r1_in = req_value;
               t0_in = '0;
               t1_in = CW'(1);
            end
         end
         minv_pkg::DP_ALIGN_INIT: begin
            d_in = r1_ff;
            e_in = t1_ff;
            k_in = '0;
         end
         minv_pkg::DP_ALIGN: begin
            if (can_shift) begin
               d_in = d_dbl[WORD_BITS-1:0];
               e_in = e_ff <<< 1;
               k_in = k_ff + KW'(1);
            end
         end
         minv_pkg::DP_SUB: begin
            // one quotient bit per step, divisor walks back down
            if (r0_ff >= d_ff) begin
               r0_in = r0_ff - d_ff;
               t0_in = t0_ff - e_ff;
            end
            if (k_ff != '0) begin
               d_in = d_ff >> 1;
               e_in = e_ff >>> 1;
               k_in = k_ff - KW'(1);
            end
         end
         minv_pkg::DP_SWAP: begin
            r0_in = r1_ff;
            r1_in = r0_ff;
            t0_in = t1_ff;
            t1_in = t0_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_inverse_in = rsp_inverse_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (op == minv_pkg::DP_EMIT_OK) begin
            rsp_inverse_in = t0_fix[WORD_BITS-1:0];
            rsp_status_in  = minv_pkg::STATUS_OK;
         end else begin
            rsp_inverse_in = '0;
            rsp_status_in  = (modulus < WORD_BITS'(2)) ? minv_pkg::STATUS_BAD_MODULUS
                                                        : minv_pkg::STATUS_NOT_INVERTIBLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      r0_ff          <= r0_in;
      r1_ff          <= r1_in;
      d_ff           <= d_in;
      t0_ff          <= t0_in;
      t1_ff          <= t1_in;
      e_ff           <= e_in;
      k_ff           <= k_in;
      rsp_inverse_ff <= rsp_inverse_in;
      rsp_status_ff  <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_inverse = rsp_inverse_ff;
   assign rsp_status  = rsp_status_ff;

   // partial remainder always below twice the shifted divisor
   assert property (@(posedge clock) disable iff (reset)
      (op == minv_pkg::DP_SUB) |-> ({1'b0, r0_ff} < d_dbl))
      else $error("minv_dpath: partial remainder out of range");

   // division step leaves remainder below divisor
   assert property (@(posedge clock) disable iff (reset)
      (op == minv_pkg::DP_SWAP) |-> (r0_ff < r1_ff))
      else $error("minv_dpath: remainder not below divisor at swap");

   // a good result lies in 1..n-1
   assert property (@(posedge clock) disable iff (reset)
      (op == minv_pkg::DP_EMIT_OK && out_free)
      |=> (rsp_inverse_ff != '0 && rsp_inverse_ff < modulus))
      else $error("minv_dpath: inverse outside 1..n-1");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int WORD_BITS = 16;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned LONG_HOLD = 400;
   localparam int unsigned END_DRAIN = 300;
   localparam logic [minv_pkg::CSR_ADDR_BITS-1:0] MODULUS_ADDR =
      {minv_pkg::REG_MODULUS, 2'b00};
   // word address past the register map: writes there must be dropped
   localparam logic [minv_pkg::CSR_ADDR_BITS-1:0] UNMAPPED_ADDR = 3'd4;

   typedef logic [WORD_BITS-1:0] word_type;

   // One predicted result beat, with the operands kept for messages
   typedef struct {
      word_type             value;
      word_type             modulus;
      word_type             inverse;
      minv_pkg::status_type status;
   } inverse_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   word_type                            req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   word_type                            rsp_inverse;
   logic [1:0]                          rsp_status;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [minv_pkg::CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [minv_pkg::CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [minv_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                                csr_pready;

   word_type           values_pending[$];   // values not yet offered
   inverse_result_type inverses_due[$];     // predictions awaiting a result beat
   word_type           modulus_shadow = word_type'(minv_pkg::MODULUS_RESET);

   bit          req_beat = 1'b0;        // req_ beat taken at the last posedge
   bit          gaps_on = 1'b0;
   bit          stalls_on = 1'b0;
   bit          hold_wanted = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_count = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned beats_in = 0;
   int unsigned beats_out = 0;
   int unsigned ok_count = 0;
   int unsigned bad_mod_count = 0;
   int unsigned not_inv_count = 0;
   int unsigned csr_writes = 0;

   modular_inverse_unit_top #(.WORD_BITS(WORD_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_inverse (rsp_inverse),
      .rsp_status  (rsp_status),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Expected result for value a under modulus n: extended Euclid on
   // 64-bit signed integers, Bezout coefficient of a folded into 0..n-1.
   function automatic inverse_result_type predict_inverse(word_type a, word_type n);
      inverse_result_type res;
      longint r0, r1, t0, t1, q, tmp, nl;
      res.value = a;
      res.modulus = n;
      res.inverse = '0;
      nl = longint'(n);
      if (n < 2) begin
         res.status = minv_pkg::STATUS_BAD_MODULUS;
      end else if (a == 0 || a >= n) begin
         res.status = minv_pkg::STATUS_NOT_INVERTIBLE;
      end else begin
         r0 = nl;
         r1 = longint'(a);
         t0 = 0;
         t1 = 1;
         while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1;
            r0 = r1;
            r1 = tmp;
            tmp = t0 - q * t1;
            t0 = t1;
            t1 = tmp;
         end
         if (r0 != 1) begin
            res.status = minv_pkg::STATUS_NOT_INVERTIBLE;
         end else begin
            if (t0 < 0) t0 = t0 + nl;
            res.inverse = word_type'(t0 % nl);
            res.status = minv_pkg::STATUS_OK;
         end
      end
      return res;
   endfunction

   // Mostly in-range values; some zero, some at or above n, some anything
   function automatic word_type pick_value(word_type n);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (n >= 2 && r < 70) return word_type'($urandom_range(1, n - 1));
      if (r < 78) return '0;
      if (n >= 2 && r < 88) return word_type'($urandom_range(n, (1 << WORD_BITS) - 1));
      return word_type'($urandom());
   endfunction

   // Idle run length: mostly none or short, now and then long
   function automatic int unsigned pick_run();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Driver: a beat stays put until taken; between beats an optional gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || req_beat) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (values_pending.size() != 0) begin
            req_valid <= 1'b1;
            req_value <= values_pending.pop_front();
            gap_left <= gaps_on ? pick_run() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: the long hold-off has priority, then random stall runs
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (hold_wanted && !hold_done) begin
         rsp_stall <= 1'b1;
         if (hold_count == LONG_HOLD - 1) hold_done <= 1'b1;
         hold_count <= hold_count + 1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
         rsp_stall <= 1'b1;
         stall_left <= pick_run();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on every req_ beat, check every rsp_ beat in order
   always @(posedge clock) begin : monitor
      inverse_result_type want;
      req_beat <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            inverses_due = {inverses_due, predict_inverse(req_value, modulus_shadow)};
            beats_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (inverses_due.size() == 0) begin
               $display("%0t: unexpected result beat: inverse %0d status %0d",
                        $time, rsp_inverse, rsp_status);
               error_count++;
            end else begin
               want = inverses_due.pop_front();
               case (want.status)
                  minv_pkg::STATUS_OK:          ok_count++;
                  minv_pkg::STATUS_BAD_MODULUS: bad_mod_count++;
                  default:                      not_inv_count++;
               endcase
               if (rsp_inverse !== want.inverse) begin
                  $display("%0t: inverse of %0d mod %0d: expected %0d, actual %0d",
                           $time, want.value, want.modulus, want.inverse, rsp_inverse);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status for %0d mod %0d: expected %0d, actual %0d",
                           $time, want.value, want.modulus, want.status, rsp_status);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, inverses_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [minv_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [minv_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == MODULUS_ADDR) modulus_shadow = data[WORD_BITS-1:0];
      csr_writes++;
   endtask

   // APB read of the modulus, checked against the shadow copy
   task automatic csr_check_modulus();
      word_type got;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= MODULUS_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata[WORD_BITS-1:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== modulus_shadow) begin
         $display("%0t: modulus readback: expected %0d, actual %0d",
                  $time, modulus_shadow, got);
         error_count++;
      end
   endtask

   // Modulus write with junk in the upper bits, then readback
   task automatic set_modulus(input word_type n);
      logic [minv_pkg::CSR_DATA_BITS-1:0] data;
      data = $urandom();
      data[WORD_BITS-1:0] = n;
      csr_write(MODULUS_ADDR, data);
      csr_check_modulus();
   endtask

   // Block until nothing is queued, offered or outstanding, then a short pause
   task automatic wait_idle();
      while (values_pending.size() != 0 || req_valid || inverses_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      word_type    n;
      int unsigned count;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset modulus 27, flat out: zero, one, two, two shared factors of three,
      // n-1, n itself, just above n and the all-ones value
      csr_check_modulus();
      values_pending = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd9, 16'd26, 16'd27,
                         16'd28, 16'hFFFF};
      wait_idle();

      gaps_on = 1'b1;
      stalls_on = 1'b1;

      // Smallest legal modulus: only one has an inverse, and it is itself
      set_modulus(16'd2);
      values_pending = '{16'd1, 16'd0, 16'd2};
      wait_idle();

      // Moduli below two reject everything
      set_modulus(16'd0);
      values_pending = '{16'd0, 16'd1, 16'hFFFF};
      wait_idle();
      set_modulus(16'd1);
      values_pending = '{16'd1};
      wait_idle();

      // A write outside the register map must leave the modulus alone
      csr_write(UNMAPPED_ADDR, 32'd7);
      csr_check_modulus();
      values_pending = '{16'd1};
      wait_idle();

      // Largest modulus, 3*5*17*257: units, shared factors, out of range
      set_modulus(16'hFFFF);
      values_pending = '{16'd1, 16'd2, 16'd3, 16'hFFFE, 16'hFFFF, 16'h8000, 16'h5555};
      wait_idle();

      // Random phases with a different modulus each
      for (int unsigned phase = 0; phase < 12; phase++) begin
         case (phase)
            0:       n = 16'd65521;                              // prime
            1:       n = word_type'($urandom_range(32768, 65535));
            2:       n = 16'hFFFF;
            3:       n = word_type'($urandom_range(2, 60));
            4:       n = 16'h8000;                               // power of two
            5:       n = word_type'($urandom_range(2, 65535));
            6:       n = word_type'($urandom_range(256, 4095));
            7:       n = 16'd1;
            8:       n = 16'd2;
            9:       n = word_type'($urandom_range(2, 65535));
            10:      n = 16'd27720;                              // many small factors
            default: n = word_type'($urandom_range(4096, 65535));
         endcase
         set_modulus(n);
         count = (n < 3) ? 10 : 42;

         // No idling at all in the first phase; in the fifth a long hold-off
         // on the result side while the sender keeps offering back to back
         gaps_on = (phase != 0 && phase != 4);
         stalls_on = (phase != 0);
         if (phase == 4) hold_wanted = 1'b1;

         repeat (count) values_pending = {values_pending, pick_value(n)};
         wait_idle();
      end

      // Let any stray beat surface before the verdict
      repeat (END_DRAIN) @(posedge clock);

      $display("Covered %0d value beats and %0d result beats over %0d CSR writes,",
               beats_in, beats_out, csr_writes);
      $display("statuses seen: %0d ok, %0d bad modulus, %0d not invertible",
               ok_count, bad_mod_count, not_inv_count);
      if (error_count == 0 && inverses_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  error_count, inverses_due.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
